[hw/rtl/bprc_pkg.sv]
`default_nettype none

package bprc_pkg;

  localparam logic [31:0] PAT_LBA_MUL = 32'd2654435761;
  localparam logic [31:0] PAT_OFF_MUL = 32'd40503;
  localparam logic [31:0] PAT_SEED    = 32'h0000_00A5;
  localparam int          PAT_SHIFT   = 13;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam int          CFG_IDX_W     = 2;
  localparam logic [1:0]  CFG_START_LBA = 2'd0;
  localparam logic [1:0]  CFG_BLOCK_SIZE = 2'd1;
  localparam logic [1:0]  CFG_RUN_BLOCKS = 2'd2;

  localparam logic [31:0] START_LBA_RST  = 32'd0;
  localparam logic [15:0] BLOCK_SIZE_RST = 16'd512;
  localparam logic [15:0] RUN_BLOCKS_RST = 16'd1;

  localparam int          Q_DEPTH_DEF = 4;

  typedef struct packed {
    logic [7:0]  expected_byte;
    logic        byte_differs;
    logic        run_end;
    logic        length_error;
    logic [31:0] position;
  } q_item_t;

  typedef struct packed {
    logic    push;
    q_item_t item;
  } q_push_t;

endpackage

`default_nettype wire

[hw/rtl/bprc_if.sv]
`default_nettype none

interface bprc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       run_end;

  modport source (output valid, output read_byte, output run_end, input ready);
  modport sink (input valid, input read_byte, input run_end, output ready);
endinterface

interface bprc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  expected_byte;
  logic        byte_differs;
  logic        run_done;
  logic        length_error;
  logic [31:0] run_mismatch_count;
  logic [31:0] first_bad_offset;
  logic [31:0] total_mismatch_count;
  logic        run_passed;

  modport source (output valid, output expected_byte, output byte_differs, output run_done,
                  output length_error, output run_mismatch_count, output first_bad_offset,
                  output total_mismatch_count, output run_passed, input ready);
  modport sink (input valid, input expected_byte, input byte_differs, input run_done,
                input length_error, input run_mismatch_count, input first_bad_offset,
                input total_mismatch_count, input run_passed, output ready);
endinterface

interface bprc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [31:0] wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

[hw/rtl/bprc_front.sv]
`default_nettype none

module bprc_front
  import bprc_pkg::*;
#(
  parameter int QDepth = Q_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bprc_in_if.sink                          in_ch,
  bprc_cfg_if.sink                         cfg_ch,
  input  wire logic [$clog2(QDepth+1)-1:0] q_count,
  output q_push_t                          q_wr
);

  localparam int CW = $clog2(QDepth + 1);

  logic [31:0] start_lba_r;
  logic [15:0] block_size_r;
  logic [15:0] run_blocks_r;
  logic [31:0] want_r;

  logic [15:0] block_idx_r;
  logic [15:0] offset_r;
  logic [31:0] bytes_seen_r;

  logic        s1_v_r;
  logic [31:0] s1_lba_r;
  logic [15:0] s1_off_r;
  logic [7:0]  s1_rd_r;
  logic        s1_end_r;
  logic [31:0] s1_pos_r;
  logic [31:0] s1_cnt_r;

  logic        s2_v_r;
  logic [31:0] s2_m1_r;
  logic [31:0] s2_m2_r;
  logic [7:0]  s2_rd_r;
  logic        s2_end_r;
  logic        s2_len_err_r;
  logic [31:0] s2_pos_r;

  logic        accept;
  logic [CW:0] in_use;
  logic [31:0] cnt_nxt;
  logic [15:0] off_inc;
  logic [15:0] offset_nxt;
  logic [15:0] block_idx_nxt;
  logic [31:0] lba_prod;
  logic [31:0] off_prod;
  logic [31:0] pat_v;
  logic [31:0] pat_mix;
  logic [7:0]  exp_byte;

  assign in_use       = {1'b0, q_count} + (CW+1)'(s1_v_r) + (CW+1)'(s2_v_r);
  assign in_ch.ready  = (in_use < (CW+1)'(QDepth));
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign cnt_nxt = (bytes_seen_r == CNT_MAX) ? CNT_MAX : bytes_seen_r + 32'd1;
  assign off_inc = offset_r + 16'd1;

  always_comb begin
    offset_nxt    = off_inc;
    block_idx_nxt = block_idx_r;
    if (off_inc == block_size_r) begin
      offset_nxt    = 16'd0;
      block_idx_nxt = block_idx_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_lba_r  <= START_LBA_RST;
      block_size_r <= BLOCK_SIZE_RST;
      run_blocks_r <= RUN_BLOCKS_RST;
      want_r       <= 32'(RUN_BLOCKS_RST) * 32'(BLOCK_SIZE_RST);
      block_idx_r  <= 16'd0;
      offset_r     <= 16'd0;
      bytes_seen_r <= 32'd0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
    end else begin
      want_r <= {16'h0000, run_blocks_r} * {16'h0000, block_size_r};
      if (cfg_ch.valid) begin
        case (cfg_ch.idx)
          CFG_START_LBA:  start_lba_r  <= cfg_ch.wdata;
          CFG_BLOCK_SIZE: block_size_r <= cfg_ch.wdata[15:0];
          CFG_RUN_BLOCKS: run_blocks_r <= cfg_ch.wdata[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (in_ch.run_end) begin
          block_idx_r  <= 16'd0;
          offset_r     <= 16'd0;
          bytes_seen_r <= 32'd0;
        end else begin
          block_idx_r  <= block_idx_nxt;
          offset_r     <= offset_nxt;
          bytes_seen_r <= cnt_nxt;
        end
      end
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lba_r <= start_lba_r + {16'h0000, block_idx_r};
      s1_off_r <= offset_r;
      s1_rd_r  <= in_ch.read_byte;
      s1_end_r <= in_ch.run_end;
      s1_pos_r <= bytes_seen_r;
      s1_cnt_r <= cnt_nxt;
    end
  end

  assign lba_prod = s1_lba_r * PAT_LBA_MUL;
  assign off_prod = {16'h0000, s1_off_r} * PAT_OFF_MUL;

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_m1_r      <= lba_prod;
      s2_m2_r      <= off_prod;
      s2_rd_r      <= s1_rd_r;
      s2_end_r     <= s1_end_r;
      s2_len_err_r <= s1_end_r && (s1_cnt_r != want_r);
      s2_pos_r     <= s1_pos_r;
    end
  end

  assign pat_v    = s2_m1_r + s2_m2_r + PAT_SEED;
  assign pat_mix  = (pat_v >> PAT_SHIFT) ^ pat_v;
  assign exp_byte = pat_mix[7:0];

  assign q_wr.push               = s2_v_r;
  assign q_wr.item.expected_byte = exp_byte;
  assign q_wr.item.byte_differs  = (s2_rd_r != exp_byte);
  assign q_wr.item.run_end       = s2_end_r;
  assign q_wr.item.length_error  = s2_len_err_r;
  assign q_wr.item.position      = s2_pos_r;

endmodule

`default_nettype wire

[hw/rtl/bprc_fifo.sv]
`default_nettype none

module bprc_fifo
  import bprc_pkg::*;
#(
  parameter int QDepth = Q_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire q_push_t                     q_wr,
  input  wire logic                        pop,
  output q_item_t                          head,
  output logic [$clog2(QDepth+1)-1:0]      count
);

  localparam int CW = $clog2(QDepth + 1);
  localparam int AW = (QDepth > 1) ? $clog2(QDepth) : 1;

  q_item_t       mem_r [QDepth];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(QDepth - 1)) ? '0 : p + AW'(1);
    return r;
  endfunction

  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (q_wr.push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !q_wr.push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bprc_back.sv]
`default_nettype none

module bprc_back
  import bprc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_valid,
  input  wire q_item_t head,
  output logic         pop,
  bprc_out_if.source   out_ch
);

  logic [31:0] run_mis_r;
  logic [31:0] first_bad_r;
  logic [31:0] total_r;
  logic        out_v_r;

  logic [7:0]  o_exp_r;
  logic        o_diff_r;
  logic        o_done_r;
  logic        o_len_err_r;
  logic [31:0] o_run_mis_r;
  logic [31:0] o_first_bad_r;
  logic [31:0] o_total_r;
  logic        o_passed_r;

  logic [31:0] run_mis_nxt;
  logic [31:0] first_bad_nxt;
  logic [32:0] tot_sum;
  logic [31:0] total_nxt;
  logic        passed;

  assign pop = q_valid && (!out_v_r || out_ch.ready);

  always_comb begin
    run_mis_nxt   = run_mis_r;
    first_bad_nxt = first_bad_r;
    if (head.byte_differs) begin
      run_mis_nxt = (run_mis_r == CNT_MAX) ? CNT_MAX : run_mis_r + 32'd1;
      if (run_mis_r == 32'd0) begin
        first_bad_nxt = head.position;
      end
    end
  end

  assign tot_sum   = {1'b0, total_r} + {1'b0, run_mis_nxt};
  assign total_nxt = (head.run_end && !head.length_error) ?
                     (tot_sum[32] ? CNT_MAX : tot_sum[31:0]) : total_r;
  assign passed    = head.run_end && !head.length_error && (run_mis_nxt == 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mis_r   <= 32'd0;
      first_bad_r <= 32'd0;
      total_r     <= 32'd0;
      out_v_r     <= 1'b0;
    end else begin
      if (pop) begin
        out_v_r <= 1'b1;
        total_r <= total_nxt;
        if (head.run_end) begin
          run_mis_r   <= 32'd0;
          first_bad_r <= 32'd0;
        end else begin
          run_mis_r   <= run_mis_nxt;
          first_bad_r <= first_bad_nxt;
        end
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      o_exp_r       <= head.expected_byte;
      o_diff_r      <= head.byte_differs;
      o_done_r      <= head.run_end;
      o_len_err_r   <= head.length_error;
      o_run_mis_r   <= run_mis_nxt;
      o_first_bad_r <= first_bad_nxt;
      o_total_r     <= total_nxt;
      o_passed_r    <= passed;
    end
  end

  assign out_ch.valid                = out_v_r;
  assign out_ch.expected_byte        = o_exp_r;
  assign out_ch.byte_differs         = o_diff_r;
  assign out_ch.run_done             = o_done_r;
  assign out_ch.length_error         = o_len_err_r;
  assign out_ch.run_mismatch_count   = o_run_mis_r;
  assign out_ch.first_bad_offset     = o_first_bad_r;
  assign out_ch.total_mismatch_count = o_total_r;
  assign out_ch.run_passed           = o_passed_r;

endmodule

`default_nettype wire

[hw/rtl/block_pattern_readback_checker_top.sv]
// Read-back pattern checker.
// Items of read-back bytes enter on in_ch, each with a run_end flag on the last
// byte of a run. Every item yields one result item on out_ch with the expected
// pattern byte, a mismatch flag, the run mismatch count, the first bad offset,
// the total mismatch count and, on the last byte, the length and pass status.
// Registers start_lba, block_size and run_blocks are written on cfg_ch at
// indexes 0, 1 and 2; cfg_ch is always ready and writes apply from the next item.
// The front tracks block and offset and computes the pattern in pipeline stages
// s1 and s2, with the two pattern products in one register stage; the back keeps
// the counters. A result goes through s1, s2, the queue and the output register;
// at the default QDepth one item per cycle is sustained while out_ch is ready.
// A queue of QDepth entries sits between front and back; in_ch.ready drops when
// the queue and the front pipeline together hold QDepth items, so a stalled
// receiver holds the output register and then the queue fills. Reset is
// synchronous: registers return to 0, 512 and 1, all counters clear.
`default_nettype none

module block_pattern_readback_checker_top
  import bprc_pkg::*;
#(
  parameter int QDepth = Q_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bprc_in_if.sink    in_ch,
  bprc_cfg_if.sink   cfg_ch,
  bprc_out_if.source out_ch
);

  localparam int CW = $clog2(QDepth + 1);

  q_push_t       q_wr;
  q_item_t       q_head;
  logic [CW-1:0] q_count;
  logic          q_pop;

  bprc_front #(.QDepth(QDepth)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_count (q_count),
    .q_wr    (q_wr)
  );

  bprc_fifo #(.QDepth(QDepth)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .head  (q_head),
    .count (q_count)
  );

  bprc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_count != '0),
    .head    (q_head),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push && (q_count == CW'(QDepth)) |-> q_pop)
    else $error("queue written while full");

  a_len_err_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.length_error |-> out_ch.run_done)
    else $error("length error outside run end");

  a_passed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.run_passed |->
      !out_ch.length_error && (out_ch.run_mismatch_count == 32'd0))
    else $error("run passed with errors");

  a_first_bad_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.first_bad_offset != 32'd0) |->
      (out_ch.run_mismatch_count != 32'd0))
    else $error("first bad offset set without mismatch");

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
  import bprc_pkg::*;

  localparam int IdleLimit = 3000;
  localparam int LongHold  = 120;
  localparam int PhaseLen  = 75;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]  exp_byte;
    logic        differs;
    logic        done;
    logic        len_err;
    logic [31:0] run_cnt;
    logic [31:0] first_bad;
    logic [31:0] total;
    logic        passed;
  } verdict_t;

  logic clk;
  logic rst_n;

  bprc_in_if  in_ch ();
  bprc_out_if out_ch ();
  bprc_cfg_if cfg_ch ();

  block_pattern_readback_checker_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  byte_item_t bytes_to_send[$];
  verdict_t   predicted_verdicts[$];

  // Register values as last written.
  logic [31:0] cfg_start_lba  = START_LBA_RST;
  logic [15:0] cfg_block_size = BLOCK_SIZE_RST;
  logic [15:0] cfg_run_blocks = RUN_BLOCKS_RST;

  // Position tracking on the checking side.
  logic [15:0] chk_blk;
  logic [15:0] chk_off;
  logic [31:0] chk_len;
  logic [31:0] chk_run_bad;
  logic [31:0] chk_first_bad;
  logic [31:0] chk_total_bad;

  // Position tracking on the stimulus side, used to build correct bytes.
  logic [15:0] stim_blk = '0;
  logic [15:0] stim_off = '0;
  int          stim_len = 0;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_requests      = 0;
  int holds_served;
  int hold_left;
  int idle_cycles;

  int error_count   = 0;
  int items_checked = 0;
  int runs_seen     = 0;
  int runs_passed   = 0;
  int runs_len_err  = 0;
  int bad_bytes     = 0;
  int reg_writes    = 0;

  function automatic logic [7:0] pattern_byte(logic [31:0] lba, logic [31:0] off);
    logic [31:0] v;
    v = lba * PAT_LBA_MUL + off * PAT_OFF_MUL + PAT_SEED;
    v = v ^ (v >> PAT_SHIFT);
    return v[7:0];
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? CNT_MAX : s[31:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 25) begin
      $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
    end
    error_count++;
  endtask

  task automatic judge_byte(input logic [7:0] rd, input logic last);
    verdict_t    v;
    logic [15:0] nxt;
    logic [31:0] want_len;
    v = '0;
    v.exp_byte = pattern_byte(cfg_start_lba + 32'(chk_blk), 32'(chk_off));
    v.differs = (rd != v.exp_byte);
    if (v.differs) begin
      if (chk_run_bad == 0) chk_first_bad = chk_len;
      chk_run_bad = sat_add(chk_run_bad, 32'd1);
      bad_bytes++;
    end
    chk_len = sat_add(chk_len, 32'd1);
    nxt = chk_off + 16'd1;
    if (nxt == cfg_block_size) begin
      nxt = '0;
      chk_blk = chk_blk + 16'd1;
    end
    chk_off = nxt;
    v.done = last;
    v.run_cnt = chk_run_bad;
    v.first_bad = chk_first_bad;
    if (last) begin
      want_len = 32'(cfg_run_blocks) * 32'(cfg_block_size);
      v.len_err = (chk_len != want_len);
      if (!v.len_err) chk_total_bad = sat_add(chk_total_bad, chk_run_bad);
      v.passed = !v.len_err && (chk_run_bad == 0);
      runs_seen++;
      if (v.passed) runs_passed++;
      if (v.len_err) runs_len_err++;
      chk_blk = '0;
      chk_off = '0;
      chk_len = '0;
      chk_run_bad = '0;
      chk_first_bad = '0;
    end
    v.total = chk_total_bad;
    predicted_verdicts = {predicted_verdicts, v};
  endtask

  task automatic add_byte(input logic [7:0] corrupt, input logic last);
    byte_item_t  it;
    logic [15:0] nxt;
    it.data = pattern_byte(cfg_start_lba + 32'(stim_blk), 32'(stim_off)) ^ corrupt;
    it.last = last;
    bytes_to_send = {bytes_to_send, it};
    nxt = stim_off + 16'd1;
    if (nxt == cfg_block_size) begin
      nxt = '0;
      stim_blk = stim_blk + 16'd1;
    end
    stim_off = nxt;
    stim_len++;
    if (last) begin
      stim_blk = '0;
      stim_off = '0;
      stim_len = 0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_START_LBA: begin
        cfg_start_lba = val;
      end
      CFG_BLOCK_SIZE: begin
        cfg_block_size = val[15:0];
      end
      CFG_RUN_BLOCKS: begin
        cfg_run_blocks = val[15:0];
      end
      default: begin
      end
    endcase
    reg_writes++;
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (bytes_to_send.size() != 0 || in_ch.valid || predicted_verdicts.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver.
  always @(posedge clk) begin : driver
    byte_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.read_byte <= '0;
      in_ch.run_end <= 1'b0;
      chk_blk = '0;
      chk_off = '0;
      chk_len = '0;
      chk_run_bad = '0;
      chk_first_bad = '0;
      chk_total_bad = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        judge_byte(in_ch.read_byte, in_ch.run_end);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          it = bytes_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.read_byte <= it.data;
          in_ch.run_end <= it.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure, including the long hold-off on request.
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      holds_served <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= LongHold;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin : monitor
    verdict_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_verdicts.size() == 0) begin
        report_mismatch("result item with none expected", 32'(out_ch.expected_byte), '0);
      end else begin
        w = predicted_verdicts.pop_front();
        items_checked++;
        if (out_ch.expected_byte !== w.exp_byte)
          report_mismatch("expected_byte", 32'(out_ch.expected_byte), 32'(w.exp_byte));
        if (out_ch.byte_differs !== w.differs)
          report_mismatch("byte_differs", 32'(out_ch.byte_differs), 32'(w.differs));
        if (out_ch.run_done !== w.done)
          report_mismatch("run_done", 32'(out_ch.run_done), 32'(w.done));
        if (out_ch.length_error !== w.len_err)
          report_mismatch("length_error", 32'(out_ch.length_error), 32'(w.len_err));
        if (out_ch.run_mismatch_count !== w.run_cnt)
          report_mismatch("run_mismatch_count", out_ch.run_mismatch_count, w.run_cnt);
        if (out_ch.first_bad_offset !== w.first_bad)
          report_mismatch("first_bad_offset", out_ch.first_bad_offset, w.first_bad);
        if (out_ch.total_mismatch_count !== w.total)
          report_mismatch("total_mismatch_count", out_ch.total_mismatch_count, w.total);
        if (out_ch.run_passed !== w.passed)
          report_mismatch("run_passed", 32'(out_ch.run_passed), 32'(w.passed));
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no item moved for %0d cycles.", IdleLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int          i;
    int          n;
    int          r;
    int          sent;
    int          target;
    logic [31:0] want;
    logic [7:0]  corrupt;
    logic        last;
    logic [15:0] bs;
    logic [15:0] rb;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.read_byte = '0;
    in_ch.run_end = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = CFG_START_LBA;
    cfg_ch.wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part. A short run under the reset settings ends with a length error.
    add_byte(8'h00, 1'b0);
    add_byte(8'h01, 1'b1);
    wait_idle();
    write_reg(CFG_START_LBA, 32'hFFFF_FFFF);
    write_reg(CFG_BLOCK_SIZE, 32'd2);
    write_reg(CFG_RUN_BLOCKS, 32'd2);
    // A clean run, a run with two bad bytes, a short run and an overlong one.
    for (i = 0; i < 4; i++) add_byte(8'h00, i == 3);
    for (i = 0; i < 4; i++) add_byte((i % 2) ? 8'h80 : 8'h00, i == 3);
    for (i = 0; i < 3; i++) add_byte((i == 2) ? 8'hFF : 8'h00, i == 2);
    for (i = 0; i < 5; i++) add_byte(8'h00, i == 4);
    wait_idle();
    // Zero block size.
    write_reg(CFG_BLOCK_SIZE, 32'd0);
    for (i = 0; i < 3; i++) add_byte(8'h00, i == 2);
    wait_idle();
    // Zero run blocks.
    write_reg(CFG_BLOCK_SIZE, 32'd3);
    write_reg(CFG_RUN_BLOCKS, 32'd0);
    for (i = 0; i < 2; i++) add_byte(8'h00, i == 1);
    wait_idle();
    write_reg(CFG_START_LBA, 32'd0);
    write_reg(CFG_BLOCK_SIZE, 32'hFFFF);
    write_reg(CFG_RUN_BLOCKS, 32'hFFFF);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b1);

    // Random part in four idling modes, two phases each.
    for (int m = 0; m < 4; m++) begin
      for (int p = 0; p < 2; p++) begin
        wait_idle();
        sender_idle_pct = (m == 1) ? 58 : (m == 3) ? 24 : 0;
        receiver_stall_pct = (m == 2) ? 58 : (m == 3) ? 24 : 0;
        r = $urandom_range(99);
        bs = (r < 8) ? 16'd0 : (r < 14) ? 16'hFFFF : 16'($urandom_range(1, 8));
        r = $urandom_range(99);
        rb = (r < 6) ? 16'd0 : (r < 10) ? 16'hFFFF : 16'($urandom_range(1, 3));
        write_reg(CFG_START_LBA, $urandom());
        write_reg(CFG_BLOCK_SIZE, 32'(bs));
        write_reg(CFG_RUN_BLOCKS, 32'(rb));
        if (m == 2 && p == 0) hold_requests++;
        sent = 0;
        while (sent < PhaseLen) begin
          want = 32'(cfg_run_blocks) * 32'(cfg_block_size);
          if (want == 0 || want > 64) begin
            target = $urandom_range(1, 10);
          end else if ($urandom_range(99) < 75) begin
            target = int'(want);
          end else begin
            target = int'(want) + int'($urandom_range(0, 4)) - 2;
          end
          n = target - stim_len;
          if (n < 1) n = 1;
          for (i = 0; i < n; i++) begin
            r = $urandom_range(99);
            corrupt = (r < 12) ? 8'(1 << $urandom_range(7)) :
                      (r < 16) ? 8'($urandom_range(1, 255)) : 8'h00;
            last = (i == n - 1);
            if (last && sent + 1 >= PhaseLen && $urandom_range(99) < 30) last = 1'b0;
            add_byte(corrupt, last);
            sent++;
          end
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Checked %0d items over %0d runs: %0d passed, %0d with length errors.",
             items_checked, runs_seen, runs_passed, runs_len_err);
    $display("Bad bytes injected and seen: %0d; register writes: %0d; mismatches: %0d.",
             bad_bytes, reg_writes, error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
